>>> rtl/core/swecb_pkg.sv
// ---------------------------------------------------------------------------
// swecb_pkg: shared types and codes of the write/erase coalescing buffer
// Command opcodes, result kinds, the buffered entry layout and the
// controller/datapath command and status groups.
// ---------------------------------------------------------------------------
package swecb_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_ERASE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam int unsigned ERASE_CHUNK = 10;
    localparam logic [9:0]  LBA_MAX     = 10'd1023;

    typedef struct packed {
        logic        erase;
        logic [9:0]  lba;
        logic [31:0] val;
    } entry_t;

    typedef struct packed {
        logic load;         // capture the input transaction
        logic emit_entry;   // emit entry at the read pointer, advance
        logic scan_step;    // compact one entry, advance
        logic scan_done;    // commit compacted count
        logic clr_count;    // drop all entries, rewind pointers
        logic append_write; // append the captured write
        logic append_chunk; // append the next erase chunk
        logic read_next;    // advance the read pointer
        logic emit_read;    // emit the read reply
        logic finish;       // release the held result as last
    } swecb_cmd_t;

    typedef struct packed {
        logic       r_lt_count;
        logic       full;
        logic       can_emit;
        logic       out_free;
        logic       pend_valid;
        logic       chunks_done;
        logic       read_match;
        logic [1:0] op;
    } swecb_stat_t;

endpackage

>>> rtl/core/swecb_datapath.sv
// ---------------------------------------------------------------------------
// swecb_datapath: entry store, scan pointers and result registers
// Holds the ordered entry store, the compaction pointers, the running erase
// union, a one-deep holding register that marks the last result, and the
// output register.
// ---------------------------------------------------------------------------
module swecb_datapath #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned CW    = $clog2(DEPTH + 1),
    parameter int unsigned IW    = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            s_op,
    input  logic [9:0]            s_lba,
    input  logic [3:0]            s_erase_size,
    input  logic [31:0]           s_write_data,
    input  swecb_pkg::swecb_cmd_t cmd,
    output swecb_pkg::swecb_stat_t stat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [9:0]            m_out_lba,
    output logic [31:0]           m_out_value,
    output logic                  m_hit,
    output logic                  m_last
);
    import swecb_pkg::*;

    entry_t      store_reg [DEPTH];
    logic [CW-1:0] count_reg, r_reg, w_reg;
    logic [1:0]  op_reg;
    logic [9:0]  lba_reg;
    logic [31:0] data_reg;
    logic [10:0] lo_reg, hi_reg;

    logic        pend_valid_reg;
    logic [1:0]  pend_kind_reg;
    logic [9:0]  pend_lba_reg;
    logic [31:0] pend_val_reg;
    logic        pend_hit_reg;

    logic        m_valid_reg, m_last_reg, m_hit_reg;
    logic [1:0]  m_kind_reg;
    logic [9:0]  m_lba_reg;
    logic [31:0] m_val_reg;

    entry_t      cur;
    logic [32:0] b_wide;
    logic [10:0] b_end, a_ext;
    logic        drop, merge;
    logic [3:0]  size_clamp;
    logic [10:0] hi_load;
    logic [10:0] chunk_len;
    logic [3:0]  chunk_c;
    logic        new_emit;
    logic [1:0]  new_kind;
    logic [9:0]  new_lba;
    logic [31:0] new_val;
    logic        new_hit;

    // Decode the entry at the read pointer against the captured command
    always_comb begin
        cur    = store_reg[r_reg[IW-1:0]];
        a_ext  = {1'b0, cur.lba};
        b_wide = (cur.val == 32'd0) ? {23'd0, cur.lba}
                                    : 33'({23'd0, cur.lba}) + {1'b0, cur.val} - 33'd1;
        b_end  = (b_wide > 33'(LBA_MAX)) ? {1'b0, LBA_MAX} : b_wide[10:0];
        drop   = 1'b0;
        merge  = 1'b0;
        if (op_reg == OP_WRITE) begin
            drop = !cur.erase && (cur.lba == lba_reg);
        end else if (!cur.erase) begin
            drop = (lo_reg <= a_ext) && (a_ext <= hi_reg);
        end else if ((lo_reg <= a_ext) && (b_end <= hi_reg)) begin
            drop = 1'b1;
        end else if (!((b_end < lo_reg) || (hi_reg < a_ext))) begin
            drop  = 1'b1;
            merge = 1'b1;
        end
    end

    // Clamp the erase size and clip the end of the range
    always_comb begin
        if (s_erase_size == 4'd0) begin
            size_clamp = 4'd1;
        end else if (s_erase_size > 4'(ERASE_CHUNK)) begin
            size_clamp = 4'(ERASE_CHUNK);
        end else begin
            size_clamp = s_erase_size;
        end
        hi_load = {1'b0, s_lba} + {7'd0, size_clamp} - 11'd1;
        if (hi_load > {1'b0, LBA_MAX}) begin
            hi_load = {1'b0, LBA_MAX};
        end
        chunk_len = hi_reg - lo_reg + 11'd1;
        chunk_c   = (chunk_len > 11'(ERASE_CHUNK)) ? 4'(ERASE_CHUNK) : chunk_len[3:0];
    end

    // Select the result produced this cycle
    always_comb begin
        new_emit = cmd.emit_entry || cmd.emit_read;
        if (cmd.emit_read) begin
            new_kind = KIND_READ;
            new_lba  = lba_reg;
            new_hit  = (r_reg < count_reg);
            new_val  = new_hit ? cur.val : 32'd0;
        end else begin
            new_kind = cur.erase ? KIND_ERASE : KIND_WRITE;
            new_lba  = cur.lba;
            new_hit  = 1'b0;
            new_val  = cur.val;
        end
    end

    // Write the entry store: compaction moves and appends
    always_ff @(posedge aclk) begin
        if (cmd.scan_step && !drop) begin
            store_reg[w_reg[IW-1:0]] <= cur;
        end
        if (cmd.append_write) begin
            store_reg[count_reg[IW-1:0]] <= '{erase: 1'b0, lba: lba_reg, val: data_reg};
        end
        if (cmd.append_chunk) begin
            store_reg[count_reg[IW-1:0]] <= '{erase: 1'b1, lba: lo_reg[9:0],
                                              val: {28'd0, chunk_c}};
        end
    end

    // Hold the captured command and the erase union
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_op;
            lba_reg  <= s_lba;
            data_reg <= s_write_data;
            lo_reg   <= {1'b0, s_lba};
            hi_reg   <= hi_load;
        end else if (cmd.scan_step && merge) begin
            if (a_ext < lo_reg) lo_reg <= a_ext;
            if (b_end > hi_reg) hi_reg <= b_end;
        end else if (cmd.append_chunk) begin
            lo_reg <= lo_reg + {7'd0, chunk_c};
        end
    end

    // Advance pointers and the entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            r_reg     <= '0;
            w_reg     <= '0;
        end else begin
            if (cmd.load || cmd.clr_count) begin
                r_reg <= '0;
                w_reg <= '0;
            end
            if (cmd.clr_count) count_reg <= '0;
            if (cmd.emit_entry || cmd.read_next) r_reg <= r_reg + CW'(1);
            if (cmd.scan_step) begin
                r_reg <= r_reg + CW'(1);
                if (!drop) w_reg <= w_reg + CW'(1);
            end
            if (cmd.scan_done) count_reg <= w_reg;
            if (cmd.append_write || cmd.append_chunk) count_reg <= count_reg + CW'(1);
        end
    end

    // Hold one result back so the final one can be marked last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (new_emit) begin
                if (pend_valid_reg) begin
                    m_valid_reg <= 1'b1;
                    m_kind_reg  <= pend_kind_reg;
                    m_lba_reg   <= pend_lba_reg;
                    m_val_reg   <= pend_val_reg;
                    m_hit_reg   <= pend_hit_reg;
                    m_last_reg  <= 1'b0;
                end else if (m_ready) begin
                    m_valid_reg <= 1'b0;
                end
                pend_valid_reg <= 1'b1;
                pend_kind_reg  <= new_kind;
                pend_lba_reg   <= new_lba;
                pend_val_reg   <= new_val;
                pend_hit_reg   <= new_hit;
            end else if (cmd.finish) begin
                m_valid_reg    <= 1'b1;
                m_kind_reg     <= pend_kind_reg;
                m_lba_reg      <= pend_lba_reg;
                m_val_reg      <= pend_val_reg;
                m_hit_reg      <= pend_hit_reg;
                m_last_reg     <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Report status to the controller
    always_comb begin
        stat.r_lt_count  = (r_reg < count_reg);
        stat.full        = (count_reg >= CW'(DEPTH));
        stat.out_free    = !m_valid_reg || m_ready;
        stat.can_emit    = !pend_valid_reg || stat.out_free;
        stat.pend_valid  = pend_valid_reg;
        stat.chunks_done = (lo_reg > hi_reg);
        stat.read_match  = !cur.erase && (cur.lba == lba_reg);
        stat.op          = op_reg;
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_out_lba   = m_lba_reg;
    assign m_out_value = m_val_reg;
    assign m_hit       = m_hit_reg;
    assign m_last      = m_last_reg;

endmodule

>>> rtl/core/swecb_ctrl.sv
// ---------------------------------------------------------------------------
// swecb_ctrl: command sequencer of the coalescing buffer
// Steps each command through flush, compaction, append, chunking and the
// read lookup, one entry per cycle, stalling on the result channel.
// ---------------------------------------------------------------------------
module swecb_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_op,
    input  swecb_pkg::swecb_stat_t stat,
    output swecb_pkg::swecb_cmd_t  cmd
);
    import swecb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PFLUSH, ST_SCAN, ST_APPEND_W, ST_CHUNK, ST_CFLUSH, ST_READ, ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Decode the command and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    unique case (s_op)
                        OP_WRITE, OP_ERASE: state_next = stat.full ? ST_PFLUSH : ST_SCAN;
                        OP_READ:            state_next = ST_READ;
                        OP_FLUSH:           state_next = ST_PFLUSH;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PFLUSH: begin
                if (stat.r_lt_count) begin
                    cmd.emit_entry = stat.can_emit;
                end else begin
                    cmd.clr_count = 1'b1;
                    state_next    = (stat.op == OP_FLUSH) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.r_lt_count) begin
                    cmd.scan_step = 1'b1;
                end else begin
                    cmd.scan_done = 1'b1;
                    state_next    = (stat.op == OP_WRITE) ? ST_APPEND_W : ST_CHUNK;
                end
            end
            ST_APPEND_W: begin
                cmd.append_write = 1'b1;
                state_next       = ST_FINISH;
            end
            ST_CHUNK: begin
                if (stat.chunks_done) begin
                    state_next = ST_FINISH;
                end else if (stat.full) begin
                    state_next = ST_CFLUSH;
                end else begin
                    cmd.append_chunk = 1'b1;
                end
            end
            ST_CFLUSH: begin
                if (stat.r_lt_count) begin
                    cmd.emit_entry = stat.can_emit;
                end else begin
                    cmd.clr_count = 1'b1;
                    state_next    = ST_CHUNK;
                end
            end
            ST_READ: begin
                if (stat.r_lt_count && !stat.read_match) begin
                    cmd.read_next = 1'b1;
                end else if (stat.can_emit) begin
                    cmd.emit_read = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

>>> rtl/core/ssd_write_erase_coalescing_buffer_core.sv
// ---------------------------------------------------------------------------
// ssd_write_erase_coalescing_buffer_core: write/erase coalescing buffer
// Top level joining the command sequencer and the entry datapath.
// ---------------------------------------------------------------------------
// One command is taken at a time; s_ready is high only while the sequencer
// is idle. A write or erase is captured, the store is scanned and compacted,
// then the write is appended, or each erase chunk in turn until the chunks
// are seen finished, and the final result is released. A read walks the
// store to the first matching write; a flush emits and clears every entry.
// A write or erase into a full store first emits and clears it. Any stall
// on the result channel holds these emissions and the final release.
// Results leave through a one-deep hold stage and an output register;
// the last result of each command has m_last set.
module ssd_write_erase_coalescing_buffer_core #(
    parameter int unsigned BUFFER_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [9:0]  s_lba,
    input  logic [3:0]  s_erase_size,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [9:0]  m_out_lba,
    output logic [31:0] m_out_value,
    output logic        m_hit,
    output logic        m_last
);
    import swecb_pkg::*;

    swecb_cmd_t  cmd;
    swecb_stat_t stat;

    swecb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .stat    (stat),
        .cmd     (cmd)
    );

    swecb_datapath #(
        .DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_op         (s_op),
        .s_lba        (s_lba),
        .s_erase_size (s_erase_size),
        .s_write_data (s_write_data),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_out_lba    (m_out_lba),
        .m_out_value  (m_out_value),
        .m_hit        (m_hit),
        .m_last       (m_last)
    );

endmodule

>>> rtl/core/swecb_checker.sv
// ---------------------------------------------------------------------------
// swecb_checker: port-level checks of the coalescing buffer
// Watches the result channel for stable stalled transactions and for
// results whose fields cannot belong together.
// ---------------------------------------------------------------------------
module swecb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [9:0]  m_out_lba,
    input logic [31:0] m_out_value,
    input logic        m_hit,
    input logic        m_last
);
    import swecb_pkg::*;

    // Hold a stalled result transaction
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_out_lba)
            && $stable(m_out_value) && $stable(m_last))
        else $error("stalled result changed");

    // A read reply is the only result of its command
    a_read_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_READ |-> m_last)
        else $error("read reply not marked last");

    // Only read replies carry a hit
    a_hit_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_kind == KIND_READ)
        else $error("hit on emitted command");

    // Emitted erases span one to ten blocks
    a_erase_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ERASE |-> m_out_value >= 32'd1 && m_out_value <= 32'd10)
        else $error("erase chunk size out of range");

endmodule

bind ssd_write_erase_coalescing_buffer_core swecb_checker u_swecb_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_out_lba   (m_out_lba),
    .m_out_value (m_out_value),
    .m_hit       (m_hit),
    .m_last      (m_last)
);

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench of the write/erase coalescing buffer
// Drives commands through the input channel, predicts the emitted commands
// and read replies with a behavioral copy of the buffer, and compares every
// result transaction in order against the predicted queue.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import swecb_pkg::*;

    localparam int unsigned DEPTH = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  lba;
        logic [31:0] value;
        logic        hit;
        logic        last;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = OP_READ;
    logic [9:0]  s_lba = '0;
    logic [3:0]  s_erase_size = 4'd1;
    logic [31:0] s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [9:0]  m_out_lba;
    logic [31:0] m_out_value;
    logic        m_hit;
    logic        m_last;

    ssd_write_erase_coalescing_buffer_core #(.BUFFER_DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_lba(s_lba),
        .s_erase_size(s_erase_size), .s_write_data(s_write_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_out_lba(m_out_lba), .m_out_value(m_out_value), .m_hit(m_hit),
        .m_last(m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // behavioral copy of the buffer
    entry_t  buf_entries[DEPTH];
    int      buf_count = 0;
    result_t pending_results[$];
    int      mismatches = 0;
    bit      quiet = 1'b0;       // no idling in the final phase
    int      hold_req = 0;       // long receiver stalls requested
    int      hold_seen = 0;      // long receiver stalls started
    int      hold_cnt = 0;       // receiver stall cycles left
    int      idle_cnt = 0;       // cycles left in a receiver idle burst

    function automatic void push_result(logic [1:0] k, logic [9:0] a, logic [31:0] v,
                                        logic h);
        result_t r;
        r.kind = k; r.lba = a; r.value = v; r.hit = h; r.last = 1'b0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void drain_buffer();
        for (int i = 0; i < buf_count; i++)
            push_result(buf_entries[i].erase ? KIND_ERASE : KIND_WRITE,
                        buf_entries[i].lba, buf_entries[i].val, 1'b0);
        buf_count = 0;
    endfunction

    function automatic void append_entry(entry_t e);
        if (buf_count >= DEPTH) drain_buffer();
        buf_entries[buf_count] = e;
        buf_count++;
    endfunction

    function automatic void predict_command(logic [1:0] op, logic [9:0] lba,
                                            logic [3:0] esize, logic [31:0] data);
        int     before_n;
        int     w;
        int     lo, hi, a, b, len, c, sz;
        entry_t e;
        before_n = pending_results.size();
        if (op == OP_WRITE || op == OP_ERASE) begin
            if (buf_count >= DEPTH) drain_buffer();
            w = 0;
            if (op == OP_WRITE) begin
                for (int r = 0; r < buf_count; r++)
                    if (buf_entries[r].erase || buf_entries[r].lba != lba)
                        buf_entries[w++] = buf_entries[r];
                buf_count = w;
                e.erase = 1'b0; e.lba = lba; e.val = data;
                append_entry(e);
            end else begin
                sz = esize;
                if (sz < 1) sz = 1;
                if (sz > ERASE_CHUNK) sz = ERASE_CHUNK;
                lo = lba;
                hi = lba + sz - 1;
                if (hi > LBA_MAX) hi = LBA_MAX;
                for (int r = 0; r < buf_count; r++) begin
                    a = buf_entries[r].lba;
                    if (!buf_entries[r].erase) begin
                        if (lo <= a && a <= hi) continue;
                    end else begin
                        b = (buf_entries[r].val == 0) ? a : a + buf_entries[r].val - 1;
                        if (b > LBA_MAX) b = LBA_MAX;
                        if (lo <= a && b <= hi) continue;
                        if (!(b < lo || hi < a)) begin
                            if (a < lo) lo = a;
                            if (b > hi) hi = b;
                            continue;
                        end
                    end
                    buf_entries[w++] = buf_entries[r];
                end
                buf_count = w;
                len = hi - lo + 1;
                while (len > 0) begin
                    c = (len > ERASE_CHUNK) ? ERASE_CHUNK : len;
                    e.erase = 1'b1; e.lba = 10'(lo); e.val = 32'(c);
                    append_entry(e);
                    lo += c;
                    len -= c;
                end
            end
        end else if (op == OP_READ) begin
            logic [31:0] v;
            logic        h;
            v = '0; h = 1'b0;
            for (int i = 0; i < buf_count; i++)
                if (!buf_entries[i].erase && buf_entries[i].lba == lba) begin
                    v = buf_entries[i].val; h = 1'b1;
                    break;
                end
            push_result(KIND_READ, lba, v, h);
        end else begin
            drain_buffer();
        end
        if (pending_results.size() > before_n)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // send one command, with an optional random gap before it
    task automatic send_command(logic [1:0] op, logic [9:0] lba, logic [3:0] esize,
                                logic [31:0] data);
        int gap;
        if (!quiet && $urandom_range(3) == 0) begin
            gap = $urandom_range(6, 1);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_lba        <= lba;
        s_erase_size <= esize;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        predict_command(op, lba, esize, data);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // receiver: random idle bursts plus requested long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt  <= 300;
            m_ready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (idle_cnt > 0) begin
            idle_cnt <= idle_cnt - 1;
            m_ready  <= 1'b0;
        end else if (!quiet && $urandom_range(4) == 0) begin
            idle_cnt <= $urandom_range(5);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_t exp_r;
            result_t got;
            got.kind = m_kind; got.lba = m_out_lba; got.value = m_out_value;
            got.hit = m_hit; got.last = m_last;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d lba=%0d value=%h hit=%b last=%b",
                             got.kind, got.lba, got.value, got.hit, got.last);
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected kind=%0d lba=%0d value=%h hit=%b last=%b",
                                 exp_r.kind, exp_r.lba, exp_r.value, exp_r.hit, exp_r.last);
                        $display("          got      kind=%0d lba=%0d value=%h hit=%b last=%b",
                                 got.kind, got.lba, got.value, got.hit, got.last);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_command(OP_FLUSH, 10'd0, 4'd1, 32'd0);              // empty flush
        send_command(OP_READ, 10'd5, 4'd1, 32'd0);               // read miss
        send_command(OP_WRITE, 10'd0, 4'd0, 32'hFFFF_FFFF);
        send_command(OP_WRITE, 10'd1023, 4'd15, 32'h0000_0000);
        send_command(OP_WRITE, 10'd0, 4'd0, 32'hA5A5_5A5A);     // replace older write
        send_command(OP_READ, 10'd0, 4'd0, 32'd0);               // read hit
        send_command(OP_ERASE, 10'd1020, 4'd15, 32'd0);          // clip at top, size > 10
        send_command(OP_ERASE, 10'd100, 4'd0, 32'd0);            // size 0 counts as 1
        send_command(OP_ERASE, 10'd101, 4'd5, 32'd0);            // adjacent: no merge
        send_command(OP_ERASE, 10'd104, 4'd10, 32'd0);           // overlap: union > 10
        send_command(OP_READ, 10'd1023, 4'd0, 32'd0);
        send_command(OP_FLUSH, 10'd0, 4'd0, 32'd0);
        for (int i = 0; i < 9; i++)                              // fill, then full flush
            send_command(OP_WRITE, 10'(i * 3), 4'd0, $urandom);
        send_command(OP_ERASE, 10'd0, 4'd10, 32'd0);
        send_command(OP_FLUSH, 10'd0, 4'd0, 32'd0);
    endtask

    task automatic send_random(int lba_span);
        logic [1:0] op;
        int         p;
        p = $urandom_range(99);
        op = (p < 40) ? OP_WRITE : (p < 70) ? OP_ERASE : (p < 90) ? OP_READ : OP_FLUSH;
        send_command(op, 10'($urandom_range(lba_span - 1)) +
                         (($urandom_range(3) == 0) ? 10'($urandom) : 10'd0),
                     4'($urandom), $urandom);
    endtask

    task automatic test_random();
        for (int i = 0; i < 300; i++) send_random(($urandom_range(1)) ? 32 : 1024);
    endtask

    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 40; i++) send_random(24);
        wait_drained();                                          // sender pause
        for (int i = 0; i < 40; i++) send_random(24);
    endtask

    task automatic test_no_idle();
        wait_drained();
        quiet = 1'b1;
        for (int i = 0; i < 80; i++) send_random(40);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        test_no_idle();
        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

>>> files.f
rtl/core/swecb_pkg.sv
rtl/core/swecb_datapath.sv
rtl/core/swecb_ctrl.sv
rtl/core/ssd_write_erase_coalescing_buffer_core.sv
rtl/core/swecb_checker.sv
tb/tb_top.sv
